// ----- hw/rtl/pal_pkg.sv -----
// ---------------------------------------------------------------------------
// pal_pkg: shared types and constants of the positional array list
// Field widths, command codes and the sequencer state type.
// ---------------------------------------------------------------------------
package pal_pkg;

  // Fixed payload widths
  localparam int WORD_W = 32;
  localparam int POS_W  = 7;
  localparam int OP_W   = 3;

  // Command codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OP_W-1:0] OP_GET    = 3'd3;
  localparam logic [OP_W-1:0] OP_LOCATE = 3'd4;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WALK  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_FINAL = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

endpackage

// ----- hw/rtl/pal_if.sv -----
// ---------------------------------------------------------------------------
// pal_if: command and result channels
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ---------------------------------------------------------------------------
interface pal_in_if;
  logic                              valid;
  logic                              ready;
  logic [pal_pkg::OP_W-1:0]          opcode;
  logic [pal_pkg::POS_W-1:0]         position;
  logic signed [pal_pkg::WORD_W-1:0] value;

  modport source (output valid, opcode, position, value, input ready);
  modport sink   (input valid, opcode, position, value, output ready);
endinterface

interface pal_out_if;
  logic                              valid;
  logic                              ready;
  logic                              ok;
  logic signed [pal_pkg::WORD_W-1:0] read_value;
  logic [pal_pkg::POS_W-1:0]         found_position;
  logic [pal_pkg::POS_W-1:0]         list_length;
  logic                              is_empty;

  modport source (output valid, ok, read_value, found_position, list_length, is_empty,
                  input ready);
  modport sink   (input valid, ok, read_value, found_position, list_length, is_empty,
                  output ready);
endinterface

// ----- hw/rtl/pal_ram.sv -----
// ---------------------------------------------------------------------------
// pal_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module pal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/positional_array_list.sv -----
// ---------------------------------------------------------------------------
// positional_array_list: ordered list of signed words with 1-based positions
// in_ch carries opcode (clear, insert, delete, get, locate), a position and
// a value; each command gives one result on out_ch: ok, the read or removed
// value, the position found by locate, the length after it and an empty flag.
// Commands run one at a time (in_ch.ready only while idle); insert, delete
// and locate move or compare one entry per cycle. Clear and refused commands
// go straight to the result; an insert at the end (p = length+1) writes its
// value in S_FINAL. Other inserts walk from the last entry down to p, moving
// each one up, then drain and write the value in S_FINAL; delete walks from
// p to the last entry, moving each one down, and drains; get reads its one
// entry; locate walks from the front and stops at the first match. S_DRAIN
// handles the last word read back in a walk. Reset empties the list; RAM
// contents are not cleared and only written positions are read. A stalled
// result is held on out_ch and no new command is taken meanwhile.
// ---------------------------------------------------------------------------
module positional_array_list #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  pal_in_if.sink       in_ch,
  pal_out_if.source    out_ch
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int PW = ((CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W) + 1;

  pal_pkg::state_t                 state_r, state_nxt;
  logic [pal_pkg::OP_W-1:0]        op_r;
  logic [CW-1:0]                   count_r;
  logic [AW-1:0]                   ptr_r;
  logic [AW-1:0]                   end_r;
  logic [AW-1:0]                   tgt_r;
  logic                            pend_r;
  logic [AW-1:0]                   pend_addr_r;
  logic [pal_pkg::WORD_W-1:0]      val_r;
  logic                            ok_r;
  logic [pal_pkg::WORD_W-1:0]      rd_r;
  logic [pal_pkg::POS_W-1:0]       found_r;

  logic                            in_xfer;
  logic [PW-1:0]                   pos_ext, cnt_ext, hit_ext;
  logic                            ins_ok, rd_ok, ins_at_end;
  logic [AW-1:0]                   pos_idx, cnt_idx;
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [pal_pkg::WORD_W-1:0]      ram_wdata, ram_rdata;
  logic                            cap_en, hit;

  assign in_xfer = in_ch.valid && in_ch.ready;

  // Command decode against the current length
  always_comb begin
    pos_ext    = PW'(in_ch.position);
    cnt_ext    = PW'(count_r);
    hit_ext    = PW'(pend_addr_r) + PW'(1);
    ins_ok     = (cnt_ext != PW'(MAX_ENTRIES)) && (pos_ext != '0) &&
                 (pos_ext <= cnt_ext + PW'(1));
    ins_at_end = (pos_ext == cnt_ext + PW'(1));
    rd_ok      = (pos_ext != '0) && (pos_ext <= cnt_ext);
    pos_idx    = AW'(pos_ext - PW'(1));
    cnt_idx    = AW'(cnt_ext - PW'(1));
  end

  // Entry storage
  pal_ram #(
    .WIDTH (pal_pkg::WORD_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  // Handling of the word read back last cycle, and the final write of the new value
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr_r;
    ram_wdata = ram_rdata;
    cap_en    = 1'b0;
    hit       = 1'b0;
    if ((state_r == pal_pkg::S_WALK || state_r == pal_pkg::S_DRAIN) && pend_r) begin
      case (op_r)
        pal_pkg::OP_INSERT: begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr_r + AW'(1);
        end
        pal_pkg::OP_DELETE: begin
          if (pend_addr_r == tgt_r) begin
            cap_en = 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = pend_addr_r - AW'(1);
          end
        end
        pal_pkg::OP_GET:    cap_en = 1'b1;
        pal_pkg::OP_LOCATE: hit = (ram_rdata == val_r);
        default: ;
      endcase
    end else if (state_r == pal_pkg::S_FINAL) begin
      ram_we    = 1'b1;
      ram_waddr = tgt_r;
      ram_wdata = val_r;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pal_pkg::S_IDLE: begin
        if (in_xfer) begin
          unique case (in_ch.opcode) inside
            pal_pkg::OP_INSERT:
              state_nxt = !ins_ok ? pal_pkg::S_RESP :
                          (ins_at_end ? pal_pkg::S_FINAL : pal_pkg::S_WALK);
            pal_pkg::OP_DELETE, pal_pkg::OP_GET:
              state_nxt = rd_ok ? pal_pkg::S_WALK : pal_pkg::S_RESP;
            pal_pkg::OP_LOCATE:
              state_nxt = (count_r != '0) ? pal_pkg::S_WALK : pal_pkg::S_RESP;
            default: state_nxt = pal_pkg::S_RESP;
          endcase
        end
      end
      pal_pkg::S_WALK: begin
        if (hit) begin
          state_nxt = pal_pkg::S_RESP;
        end else if (ptr_r == end_r) begin
          state_nxt = pal_pkg::S_DRAIN;
        end
      end
      pal_pkg::S_DRAIN: begin
        state_nxt = (!hit && op_r == pal_pkg::OP_INSERT) ? pal_pkg::S_FINAL
                                                         : pal_pkg::S_RESP;
      end
      pal_pkg::S_FINAL: state_nxt = pal_pkg::S_RESP;
      pal_pkg::S_RESP: begin
        if (out_ch.ready) begin
          state_nxt = pal_pkg::S_IDLE;
        end
      end
      default: state_nxt = pal_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pal_pkg::S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == pal_pkg::S_IDLE && in_xfer) begin
        pend_r <= 1'b0;
        unique case (in_ch.opcode)
          pal_pkg::OP_CLEAR:  count_r <= '0;
          pal_pkg::OP_INSERT: if (ins_ok) count_r <= count_r + CW'(1);
          pal_pkg::OP_DELETE: if (rd_ok) count_r <= count_r - CW'(1);
          default: ;
        endcase
      end else if (state_r == pal_pkg::S_WALK) begin
        pend_r <= 1'b1;
      end else if (state_r == pal_pkg::S_DRAIN) begin
        pend_r <= 1'b0;
      end
    end
  end

  // Walk pointer and result payload
  always_ff @(posedge clk) begin
    if (state_r == pal_pkg::S_IDLE && in_xfer) begin
      op_r    <= in_ch.opcode;
      val_r   <= in_ch.value;
      tgt_r   <= pos_idx;
      rd_r    <= '0;
      found_r <= '0;
      ok_r    <= 1'b0;
      ptr_r   <= pos_idx;
      end_r   <= pos_idx;
      unique case (in_ch.opcode)
        pal_pkg::OP_CLEAR: ok_r <= 1'b1;
        pal_pkg::OP_INSERT: begin
          ok_r  <= ins_ok;
          ptr_r <= cnt_idx;
        end
        pal_pkg::OP_DELETE: begin
          ok_r  <= rd_ok;
          end_r <= cnt_idx;
        end
        pal_pkg::OP_GET: ok_r <= rd_ok;
        pal_pkg::OP_LOCATE: begin
          ptr_r <= '0;
          end_r <= cnt_idx;
        end
        default: ;
      endcase
    end else begin
      if (state_r == pal_pkg::S_WALK) begin
        pend_addr_r <= ptr_r;
        ptr_r       <= (op_r == pal_pkg::OP_INSERT) ? ptr_r - AW'(1) : ptr_r + AW'(1);
      end
      if (cap_en) begin
        rd_r <= ram_rdata;
      end
      if (hit) begin
        ok_r    <= 1'b1;
        found_r <= hit_ext[pal_pkg::POS_W-1:0];
      end
    end
  end

  // Channel outputs
  assign in_ch.ready           = (state_r == pal_pkg::S_IDLE);
  assign out_ch.valid          = (state_r == pal_pkg::S_RESP);
  assign out_ch.ok             = ok_r;
  assign out_ch.read_value     = rd_r;
  assign out_ch.found_position = found_r;
  assign out_ch.list_length    = cnt_ext[pal_pkg::POS_W-1:0];
  assign out_ch.is_empty       = (count_r == '0);

endmodule

// ----- hw/rtl/pal_checker.sv -----
// ---------------------------------------------------------------------------
// pal_checker: port-level checks of the positional array list
// Watches both channels and flags result and flow-control slips.
// ---------------------------------------------------------------------------
module pal_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_ok,
  input logic signed [pal_pkg::WORD_W-1:0] out_read_value,
  input logic [pal_pkg::POS_W-1:0]         out_found_position,
  input logic [pal_pkg::POS_W-1:0]         out_list_length,
  input logic                              out_is_empty
);

  // A pending result holds until transferred
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value) && $stable(out_ok))
    else $error("result changed while stalled");

  // One command in flight: no new command while a result waits
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("command taken while result pending");

  // Empty flag agrees with the reported length
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_list_length == '0)))
    else $error("empty flag disagrees with length");

  // A found position or a read value implies success
  a_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> (out_found_position == '0) && (out_read_value == '0))
    else $error("refused command carries data");

endmodule

bind positional_array_list pal_checker u_pal_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_ok             (out_ch.ok),
  .out_read_value     (out_ch.read_value),
  .out_found_position (out_ch.found_position),
  .out_list_length    (out_ch.list_length),
  .out_is_empty       (out_ch.is_empty)
);

// ----- dv/pal_list_monitor.sv -----
// ---------------------------------------------------------------------------
// pal_list_monitor: result prediction and checking for the array list
// Watches both channels of positional_array_list. Each command transfer runs
// through a shadow copy of the list to get the expected result, which is
// queued in order; each result transfer is compared field by field with the
// oldest queued result.
// ---------------------------------------------------------------------------
module pal_list_monitor #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic clk,
  input  logic rst_n,
  pal_in_if    in_ch,
  pal_out_if   out_ch,
  output int   mismatch_count,
  output int   results_owed
);

  localparam int WORD_W = pal_pkg::WORD_W;
  localparam int POS_W  = pal_pkg::POS_W;
  localparam int OP_W   = pal_pkg::OP_W;

  typedef struct {
    logic                     ok;
    logic signed [WORD_W-1:0] read_value;
    logic [POS_W-1:0]         found_position;
    logic [POS_W-1:0]         list_length;
    logic                     is_empty;
  } list_result_t;

  // Shadow copy of the list contents and length
  logic signed [WORD_W-1:0] shadow_words [MAX_ENTRIES];
  int unsigned              shadow_len;
  list_result_t             awaited_results [$];

  initial begin
    mismatch_count = 0;
    results_owed   = 0;
    shadow_len     = 0;
  end

  // Apply one command to the shadow list and return the result it gives
  function automatic list_result_t apply_list_cmd(input logic [OP_W-1:0] op,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic signed [WORD_W-1:0] val);
    list_result_t res;
    int unsigned  p;
    res.ok             = 1'b0;
    res.read_value     = '0;
    res.found_position = '0;
    p = pos;
    case (op)
      pal_pkg::OP_CLEAR: begin
        shadow_len = 0;
        res.ok     = 1'b1;
      end
      pal_pkg::OP_INSERT: begin
        if (shadow_len < MAX_ENTRIES && p >= 1 && p <= shadow_len + 1) begin
          for (int unsigned j = shadow_len; j > p - 1; j--)
            shadow_words[j] = shadow_words[j-1];
          shadow_words[p-1] = val;
          shadow_len++;
          res.ok = 1'b1;
        end
      end
      pal_pkg::OP_DELETE: begin
        if (p >= 1 && p <= shadow_len) begin
          res.read_value = shadow_words[p-1];
          for (int unsigned j = p; j < shadow_len; j++)
            shadow_words[j-1] = shadow_words[j];
          shadow_len--;
          res.ok = 1'b1;
        end
      end
      pal_pkg::OP_GET: begin
        if (p >= 1 && p <= shadow_len) begin
          res.read_value = shadow_words[p-1];
          res.ok         = 1'b1;
        end
      end
      pal_pkg::OP_LOCATE: begin
        // first match wins
        for (int unsigned j = 0; j < shadow_len; j++) begin
          if (shadow_words[j] == val) begin
            res.found_position = POS_W'(j + 1);
            res.ok             = 1'b1;
            break;
          end
        end
      end
      default: ;  // unused codes change nothing
    endcase
    res.list_length = POS_W'(shadow_len);
    res.is_empty    = (shadow_len == 0);
    return res;
  endfunction

  function automatic void check_field(input string name,
                                      input logic signed [WORD_W:0] want_v,
                                      input logic signed [WORD_W:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  // Results are checked before a command in the same cycle is predicted
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (!rst_n) begin
      shadow_len = 0;
      awaited_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.ok             = out_ch.ok;
        got.read_value     = out_ch.read_value;
        got.found_position = out_ch.found_position;
        got.list_length    = out_ch.list_length;
        got.is_empty       = out_ch.is_empty;
        if (awaited_results.size() == 0) begin
          $error("result transfer with no command outstanding");
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("ok", want.ok, got.ok);
          check_field("read_value", want.read_value, got.read_value);
          check_field("found_position", want.found_position, got.found_position);
          check_field("list_length", want.list_length, got.list_length);
          check_field("is_empty", want.is_empty, got.is_empty);
        end
      end
      if (in_ch.valid && in_ch.ready)
        awaited_results.push_back(apply_list_cmd(in_ch.opcode, in_ch.position,
                                                 in_ch.value));
    end
    results_owed = awaited_results.size();
  end

endmodule

// ----- dv/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench: command stimulus and verdict for positional_array_list
// A directed pass over empty-list refusals, range edges, duplicates and the
// unused codes, then random episodes that fill the list to capacity, drain
// it and mix commands, with random idle bursts on both channels.
// ---------------------------------------------------------------------------
module testbench;

  localparam int WORD_W       = pal_pkg::WORD_W;
  localparam int POS_W        = pal_pkg::POS_W;
  localparam int OP_W         = pal_pkg::OP_W;
  localparam int LIST_DEPTH   = 64;
  localparam int ITEM_TOTAL   = 1350;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = LIST_DEPTH + 8;
  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = pal_pkg::OP_LOCATE + 1;

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   mismatch_count;
  int   results_owed;

  // Stimulus shaping state
  int   idle_pct;
  int   quiet_from;
  int   hint_len;
  int   sent;
  logic signed [WORD_W-1:0] value_pool [$];

  pal_in_if  cmd_if ();
  pal_out_if rsp_if ();

  positional_array_list #(
    .MAX_ENTRIES(LIST_DEPTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_if),
    .out_ch (rsp_if)
  );

  pal_list_monitor #(
    .MAX_ENTRIES(LIST_DEPTH)
  ) u_monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (cmd_if),
    .out_ch         (rsp_if),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random stall bursts while idling is enabled
  initial begin : result_sink
    int stall_left;
    stall_left    = 0;
    rsp_if.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        stall_left = $urandom_range(1, 4);
      if (stall_left > 0) begin
        rsp_if.ready = 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                          input logic signed [WORD_W-1:0] val);
    int gap;
    int unsigned p;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      cmd_if.valid = 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    cmd_if.valid    = 1'b1;
    cmd_if.opcode   = op;
    cmd_if.position = pos;
    cmd_if.value    = val;
    do @(posedge clk); while (!cmd_if.ready);
    @(negedge clk);
    // track the length to steer positions and the inserted values to pick from
    p = pos;
    case (op)
      pal_pkg::OP_CLEAR: hint_len = 0;
      pal_pkg::OP_INSERT: begin
        if (hint_len < LIST_DEPTH && p >= 1 && p <= hint_len + 1) begin
          hint_len++;
          value_pool.push_back(val);
          if (value_pool.size() > 24) void'(value_pool.pop_front());
        end
      end
      pal_pkg::OP_DELETE: if (p >= 1 && p <= hint_len) hint_len--;
      default: ;
    endcase
    sent++;
  endtask

  // Values: often one already stored, sometimes small (duplicates), else any
  function automatic logic signed [WORD_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0 && value_pool.size() > 0)
      return value_pool[$urandom_range(0, value_pool.size() - 1)];
    if (r == 1)
      return WORD_W'($urandom_range(0, 15)) - WORD_W'(8);
    return $urandom;
  endfunction

  task automatic random_cmd(input int ins_pct, input int del_pct, input int clr_pct);
    int r;
    int top_pos;
    logic [OP_W-1:0] op;
    logic [POS_W-1:0] pos;
    if (sent >= quiet_from) idle_pct = 0;
    r = $urandom_range(0, 99);
    if (r < 2) op = OP_FIRST_UNUSED + OP_W'($urandom_range(0, 2));
    else if (r < 2 + clr_pct) op = pal_pkg::OP_CLEAR;
    else if (r < 2 + clr_pct + ins_pct) op = pal_pkg::OP_INSERT;
    else if (r < 2 + clr_pct + ins_pct + del_pct) op = pal_pkg::OP_DELETE;
    else op = (r % 2 == 1) ? pal_pkg::OP_GET : pal_pkg::OP_LOCATE;
    // mostly legal positions, ends favored, some out of range
    top_pos = (op == pal_pkg::OP_INSERT) ? hint_len + 1 : hint_len;
    r = $urandom_range(0, 99);
    if (r < 8 || top_pos == 0) pos = POS_W'($urandom_range(0, LIST_DEPTH + 1));
    else if (r < 10) pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));
    else if (r < 25) pos = 1;
    else if (r < 40) pos = POS_W'(top_pos);
    else pos = POS_W'($urandom_range(1, top_pos));
    send_cmd(op, pos, pick_value());
  endtask

  initial begin : stimulus
    rst_n           = 1'b0;
    cmd_if.valid    = 1'b0;
    cmd_if.opcode   = pal_pkg::OP_CLEAR;
    cmd_if.position = '0;
    cmd_if.value    = '0;
    idle_pct        = 0;
    hint_len        = 0;
    sent            = 0;
    quiet_from      = ITEM_TOTAL * 85 / 100;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: refusals on an empty list
    idle_pct = 20;
    send_cmd(pal_pkg::OP_GET, 1, 0);
    send_cmd(pal_pkg::OP_DELETE, 1, 0);
    send_cmd(pal_pkg::OP_LOCATE, 0, 0);
    send_cmd(pal_pkg::OP_INSERT, 0, 5);
    send_cmd(pal_pkg::OP_INSERT, 2, 5);
    // front, back and middle inserts with extreme values
    send_cmd(pal_pkg::OP_INSERT, 1, 32'sh8000_0000);
    send_cmd(pal_pkg::OP_INSERT, 2, 32'sh7fff_ffff);
    send_cmd(pal_pkg::OP_INSERT, 1, 0);
    send_cmd(pal_pkg::OP_INSERT, 2, -32'sd1);
    send_cmd(pal_pkg::OP_INSERT, 5, -32'sd1);
    send_cmd(pal_pkg::OP_GET, 5, 0);
    send_cmd(pal_pkg::OP_GET, 6, 0);
    send_cmd(pal_pkg::OP_GET, 7'h7f, 0);
    // duplicate value: first position is reported
    send_cmd(pal_pkg::OP_LOCATE, 0, -32'sd1);
    send_cmd(pal_pkg::OP_LOCATE, 0, 32'sh7fff_ffff);
    send_cmd(pal_pkg::OP_LOCATE, 0, 12345);
    send_cmd(pal_pkg::OP_DELETE, 1, 0);
    send_cmd(pal_pkg::OP_DELETE, 4, 0);
    send_cmd(pal_pkg::OP_DELETE, 0, 0);
    send_cmd(pal_pkg::OP_DELETE, 4, 0);
    send_cmd(OP_FIRST_UNUSED, 1, 1);
    send_cmd(OP_FIRST_UNUSED + 1, 1, 1);
    send_cmd(OP_FIRST_UNUSED + 2, 7'h7f, -32'sd1);
    send_cmd(pal_pkg::OP_CLEAR, 0, 0);
    send_cmd(pal_pkg::OP_GET, 1, 0);

    // Random episodes: fill to capacity, push on a full list, drain, mix
    while (sent < ITEM_TOTAL) begin
      idle_pct = 10 * $urandom_range(0, 4);
      while (hint_len < LIST_DEPTH && sent < ITEM_TOTAL) random_cmd(65, 10, 0);
      repeat (6) if (sent < ITEM_TOTAL) random_cmd(80, 5, 0);
      idle_pct = 10 * $urandom_range(0, 4);
      while (hint_len > 0 && sent < ITEM_TOTAL) random_cmd(10, 65, 0);
      idle_pct = 10 * $urandom_range(0, 4);
      repeat (100) if (sent < ITEM_TOTAL) random_cmd(30, 25, 1);
    end
    cmd_if.valid = 1'b0;

    // Let every outstanding result arrive, then a latency's worth more
    while (results_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/pal_pkg.sv
hw/rtl/pal_if.sv
hw/rtl/pal_ram.sv
hw/rtl/positional_array_list.sv
hw/rtl/pal_checker.sv
dv/pal_list_monitor.sv
dv/testbench.sv
